>>> hdl/fbv_pkg.sv
// Shared types and constants of the frustum bounding volume cull block.
// Depends on nothing; every other file but fbv_if imports it.
package fbv_pkg;

	// Plane coefficient slot width, fixed by the register packing
	localparam int COEF_W     = 16;
	localparam int NUM_PLANES = 6;
	localparam int CFG_DATA_W = 4 * COEF_W;
	localparam int CFG_IDX_W  = 3;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		PLANE_NEAR   = 3'd0,
		PLANE_FAR    = 3'd1,
		PLANE_LEFT   = 3'd2,
		PLANE_RIGHT  = 3'd3,
		PLANE_TOP    = 3'd4,
		PLANE_BOTTOM = 3'd5
	} plane_idx_t;

	// Volume test commands
	localparam logic CMD_SPHERE = 1'b0;
	localparam logic CMD_BOX    = 1'b1;

	// One plane register, a in the low slot, d in the high slot
	typedef struct packed {
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} plane_t;

	// Per-stage advance enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

>>> hdl/fbv_if.sv
// Valid/ready channels of the frustum bounding volume cull block:
// the volume word going in and the verdict word coming out. Uses no package.
interface fbv_in_if #(
	parameter int CW = 16
);
	logic          valid;
	logic          ready;
	logic          command;
	logic signed [CW-1:0] first_x;
	logic signed [CW-1:0] first_y;
	logic signed [CW-1:0] first_z;
	logic signed [CW-1:0] box_max_x;
	logic signed [CW-1:0] box_max_y;
	logic signed [CW-1:0] box_max_z;
	logic [CW-2:0] radius;

	modport source (
		output valid, command, first_x, first_y, first_z,
		output box_max_x, box_max_y, box_max_z, radius,
		input  ready
	);
	modport sink (
		input  valid, command, first_x, first_y, first_z,
		input  box_max_x, box_max_y, box_max_z, radius,
		output ready
	);
endinterface

interface fbv_out_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

>>> hdl/fbv_plane_regs.sv
// Six plane registers written through the plain configuration port.
// Depends on fbv_pkg.
module fbv_plane_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbv_pkg::CFG_DATA_W-1:0] cfg_data,
	output fbv_pkg::plane_t                planes [fbv_pkg::NUM_PLANES]
);
	import fbv_pkg::*;

	plane_t planes_q [NUM_PLANES];

	// Store a word to its plane; indexes past the last plane are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
			planes_q[cfg_index] <= plane_t'(cfg_data);
		end
	end

	assign planes = planes_q;

endmodule

>>> hdl/fbv_plane_unit.sv
// Product stage for one plane: picks the corner or center, multiplies by
// a, b, c and forms the offset term. Depends on fbv_pkg.
module fbv_plane_unit #(
	parameter int CW = 16,
	parameter int BW = 18
) (
	input  logic                  clk,
	input  logic                  en,
	input  fbv_pkg::plane_t       plane,
	input  logic                  command,
	input  logic signed [CW-1:0]  lo_x,
	input  logic signed [CW-1:0]  lo_y,
	input  logic signed [CW-1:0]  lo_z,
	input  logic signed [CW-1:0]  hi_x,
	input  logic signed [CW-1:0]  hi_y,
	input  logic signed [CW-1:0]  hi_z,
	input  logic [CW-2:0]         radius,
	output logic signed [fbv_pkg::COEF_W+CW-1:0] prod_x_s2,
	output logic signed [fbv_pkg::COEF_W+CW-1:0] prod_y_s2,
	output logic signed [fbv_pkg::COEF_W+CW-1:0] prod_z_s2,
	output logic signed [BW-1:0]  bias_s2
);
	import fbv_pkg::*;

	logic signed [CW-1:0] sel_x, sel_y, sel_z;
	logic signed [BW-1:0] bias;

	// Box: take max coordinate for a non-negative coefficient, min otherwise.
	// Sphere: take the center.
	function automatic logic signed [CW-1:0] pick(
		input logic                 is_box,
		input logic                 neg,
		input logic signed [CW-1:0] lo,
		input logic signed [CW-1:0] hi
	);
		logic lo_gt;
		lo_gt = (lo > hi);
		if (!is_box) begin
			pick = lo;
		end else if (neg) begin
			pick = lo_gt ? hi : lo;
		end else begin
			pick = lo_gt ? lo : hi;
		end
	endfunction

	always_comb begin
		sel_x = pick(command == CMD_BOX, plane.a[COEF_W-1], lo_x, hi_x);
		sel_y = pick(command == CMD_BOX, plane.b[COEF_W-1], lo_y, hi_y);
		sel_z = pick(command == CMD_BOX, plane.c[COEF_W-1], lo_z, hi_z);
	end

	// Fold the sphere radius into d; the shift by the fraction bits comes later
	always_comb begin
		bias = {{(BW-COEF_W){plane.d[COEF_W-1]}}, plane.d};
		if (command == CMD_SPHERE) begin
			bias = bias + $signed({{(BW-CW+1){1'b0}}, radius});
		end
	end

	// Register the products and the offset term
	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s2 <= plane.a * sel_x;
			prod_y_s2 <= plane.b * sel_y;
			prod_z_s2 <= plane.c * sel_z;
			bias_s2   <= bias;
		end
	end

endmodule

>>> hdl/frustum_bounding_volume_cull.sv
// Frustum cull of sphere and box volumes against six configured planes.
// Depends on fbv_pkg, fbv_if, fbv_plane_regs and fbv_plane_unit.
//
// Usage:
//   Write the six planes through cfg_we/cfg_index/cfg_data while the block
//   is idle (index 0 near, 1 far, 2 left, 3 right, 4 top, 5 bottom; 6 and 7
//   are ignored). Each plane packs a, b, c in Q1.COEF_FRAC_BITS and d.
//   Send volume words on the volume channel: command 0 tests a sphere
//   (first_* is the center, radius used), command 1 an axis aligned box
//   (first_* and box_max_* are opposite corners, in either order).
//   One verdict word per volume comes back on the verdict channel.
// Timing:
//   Three stages: input register, product register (one multiplier per
//   coefficient), result register after the per-plane sums. A volume
//   accepted into the input register moves on through the product and
//   result registers to the channel; one volume is taken every cycle
//   unless all stages are full under a stalled verdict.
// Reset:
//   Clears all planes to zero (everything visible) and empties the stages.
// Stall:
//   A stalled verdict holds its word; earlier stages keep filling empty
//   slots, and volume.ready drops only once all three stages are full.
module frustum_bounding_volume_cull #(
	parameter int COORD_WIDTH    = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbv_pkg::CFG_DATA_W-1:0] cfg_data,
	fbv_in_if.sink                         volume,
	fbv_out_if.source                      verdict
);
	import fbv_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int PW    = COEF_W + CW;
	localparam int BW    = ((COEF_W > CW) ? COEF_W : CW) + 1;
	localparam int OW    = BW + COEF_FRAC_BITS;
	localparam int SUM_W = ((PW > OW) ? PW : OW) + 2;

	plane_t    planes [NUM_PLANES];
	stage_en_t en;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 command_s1;
	logic signed [CW-1:0] lo_x_s1, lo_y_s1, lo_z_s1;
	logic signed [CW-1:0] hi_x_s1, hi_y_s1, hi_z_s1;
	logic [CW-2:0]        radius_s1;
	logic                 visible_s3;

	logic signed [PW-1:0]    prod_x_s2 [NUM_PLANES];
	logic signed [PW-1:0]    prod_y_s2 [NUM_PLANES];
	logic signed [PW-1:0]    prod_z_s2 [NUM_PLANES];
	logic signed [BW-1:0]    bias_s2   [NUM_PLANES];
	logic signed [SUM_W-1:0] plane_dist [NUM_PLANES];
	logic [NUM_PLANES-1:0]   reject;

	fbv_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en.s3 = !valid_s3 || verdict.ready;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign volume.ready = en.s1;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= volume.valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en.s1) begin
			command_s1 <= volume.command;
			lo_x_s1    <= volume.first_x;
			lo_y_s1    <= volume.first_y;
			lo_z_s1    <= volume.first_z;
			hi_x_s1    <= volume.box_max_x;
			hi_y_s1    <= volume.box_max_y;
			hi_z_s1    <= volume.box_max_z;
			radius_s1  <= volume.radius;
		end
	end

	// One product stage per plane
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		fbv_plane_unit #(
			.CW (CW),
			.BW (BW)
		) u_unit (
			.clk       (clk),
			.en        (en.s2),
			.plane     (planes[p]),
			.command   (command_s1),
			.lo_x      (lo_x_s1),
			.lo_y      (lo_y_s1),
			.lo_z      (lo_z_s1),
			.hi_x      (hi_x_s1),
			.hi_y      (hi_y_s1),
			.hi_z      (hi_z_s1),
			.radius    (radius_s1),
			.prod_x_s2 (prod_x_s2[p]),
			.prod_y_s2 (prod_y_s2[p]),
			.prod_z_s2 (prod_z_s2[p]),
			.bias_s2   (bias_s2[p])
		);
	end

	// Sum each plane's distance; a negative sum rejects the volume
	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			plane_dist[i] = SUM_W'(prod_x_s2[i]) + SUM_W'(prod_y_s2[i])
				+ SUM_W'(prod_z_s2[i]) + (SUM_W'(bias_s2[i]) <<< COEF_FRAC_BITS);
			reject[i] = plane_dist[i][SUM_W-1];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (en.s3) begin
			visible_s3 <= ~|reject;
		end
	end

	assign verdict.valid   = valid_s3;
	assign verdict.visible = visible_s3;

	// A full pipeline under a stalled verdict keeps every word
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !verdict.ready
		|=> valid_s1 && valid_s2 && valid_s3)
		else $error("full pipeline lost a word under stall");

	// A new verdict only comes from a word in the product stage
	a_s3_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !$past(valid_s3) |-> $past(valid_s2))
		else $error("verdict appeared without a product word");

	// Ready is low only when all stages hold words and the verdict stalls
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!volume.ready |-> valid_s1 && valid_s2 && valid_s3 && !verdict.ready)
		else $error("volume channel stalled with a free stage");

endmodule

>>> tb/fbv_cull_checker.sv
// Scoreboard of the frustum cull testbench: follows plane writes, predicts
// one verdict word per volume word and compares. Depends on fbv_pkg and fbv_if.
module fbv_cull_checker #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbv_pkg::CFG_DATA_W-1:0] cfg_data,
	fbv_in_if                              volume,
	fbv_out_if                             verdict,
	output int                             mismatches,
	output int                             outstanding
);
	import fbv_pkg::*;

	localparam longint SCALE = longint'(1) <<< COEF_FRAC_BITS;

	plane_t shadow_plane [NUM_PLANES];
	logic   expected_visible [$];
	logic   want_visible;

	function automatic longint larger(input longint p, input longint q);
		return (p > q) ? p : q;
	endfunction

	// Test one volume against the shadow planes; any rejecting plane hides it
	function automatic logic cull_visible(
		input logic                command,
		input logic signed [15:0]  lx,
		input logic signed [15:0]  ly,
		input logic signed [15:0]  lz,
		input logic signed [15:0]  hx,
		input logic signed [15:0]  hy,
		input logic signed [15:0]  hz,
		input logic        [14:0]  radius
	);
		longint a, b, c, d, distance, reach;
		logic   vis;
		int     i;
		vis   = 1'b1;
		reach = longint'(radius) * SCALE;
		for (i = 0; i < NUM_PLANES; i++) begin
			a = longint'($signed(shadow_plane[i].a));
			b = longint'($signed(shadow_plane[i].b));
			c = longint'($signed(shadow_plane[i].c));
			d = longint'($signed(shadow_plane[i].d)) * SCALE;
			if (command == CMD_BOX) begin
				// take the corner farthest along the normal
				distance = larger(a * longint'(lx), a * longint'(hx))
				         + larger(b * longint'(ly), b * longint'(hy))
				         + larger(c * longint'(lz), c * longint'(hz)) + d;
				if (distance < 0)
					vis = 1'b0;
			end else begin
				distance = a * longint'(lx) + b * longint'(ly) + c * longint'(lz) + d;
				if (distance < -reach)
					vis = 1'b0;
			end
		end
		return vis;
	endfunction

	// Compare verdicts, queue predictions, then follow plane writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++)
				shadow_plane[i] = '0;
			expected_visible.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (verdict.valid && verdict.ready) begin
				if (expected_visible.size() == 0) begin
					$error("unexpected verdict word: visible %0b", verdict.visible);
					mismatches++;
				end else begin
					want_visible = expected_visible.pop_front();
					if (verdict.visible !== want_visible) begin
						$error("visible mismatch: expected %0b, actual %0b",
							want_visible, verdict.visible);
						mismatches++;
					end
				end
			end
			if (volume.valid && volume.ready)
				expected_visible.push_back(cull_visible(volume.command,
					volume.first_x, volume.first_y, volume.first_z,
					volume.box_max_x, volume.box_max_y, volume.box_max_z,
					volume.radius));
			// indexes past the last plane are dropped by the block
			if (cfg_we && cfg_index < NUM_PLANES)
				shadow_plane[cfg_index] = plane_t'(cfg_data);
			outstanding = expected_visible.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the frustum cull testbench: clock, reset, plane writes and volume
// stimulus; fbv_cull_checker does the prediction. Depends on fbv_pkg and fbv_if.
module testbench;
	import fbv_pkg::*;

	localparam int COORD_W           = 16;
	localparam int FRAC_BITS         = 14;
	localparam int UNIT              = 1 << FRAC_BITS;
	localparam int COEF_MAX          = 32767;
	localparam int COEF_MIN          = -32768;
	localparam int RADIUS_MAX        = 32767;
	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int DRAIN_CYCLES      = 8;
	localparam int ITEMS_PER_SETTING = 33;

	typedef enum int {
		PLANES_AXIS,
		PLANES_TILTED,
		PLANES_RANDOM,
		PLANES_MAX,
		PLANES_MIN
	} plane_set_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    send_idle_pct;
	int                    recv_idle_pct;
	int                    mismatches;
	int                    outstanding;
	int                    quiet_cycles;

	fbv_in_if #(.CW(COORD_W)) volume_ch ();
	fbv_out_if                verdict_ch ();

	frustum_bounding_volume_cull #(
		.COORD_WIDTH    (COORD_W),
		.COEF_FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.volume    (volume_ch),
		.verdict   (verdict_ch)
	);

	fbv_cull_checker #(
		.COEF_FRAC_BITS (FRAC_BITS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.volume      (volume_ch),
		.verdict     (verdict_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the verdict channel at random
	always @(negedge clk) begin
		verdict_ch.ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// Give up after too many cycles without a word moving
	always @(posedge clk) begin
		if ((volume_ch.valid && volume_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic plane_t pack_plane(input int a, input int b, input int c, input int d);
		plane_t pl;
		pl.a = a[COEF_W-1:0];
		pl.b = b[COEF_W-1:0];
		pl.c = c[COEF_W-1:0];
		pl.d = d[COEF_W-1:0];
		return pl;
	endfunction

	// Mostly a window around the origin, sometimes full range or the extremes
	function automatic int random_coord();
		case ($urandom_range(3))
			0, 1: return int'($urandom_range(8000)) - 4000;
			2: return int'($urandom_range(65535)) - 32768;
			default: begin
				case ($urandom_range(2))
					0: return COEF_MIN;
					1: return COEF_MAX;
					default: return 0;
				endcase
			end
		endcase
	endfunction

	function automatic int random_radius();
		case ($urandom_range(3))
			0, 1: return $urandom_range(3000);
			2: return $urandom_range(RADIUS_MAX);
			default: return $urandom_range(1) ? RADIUS_MAX : 0;
		endcase
	endfunction

	task automatic load_plane(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_plane_set(input plane_set_t kind);
		int p, a, b, c, d;
		for (p = 0; p < NUM_PLANES; p++) begin
			a = 0;
			b = 0;
			c = 0;
			d = 0;
			case (kind)
				PLANES_AXIS: begin
					d = $urandom_range(100, 6000);
					case (plane_idx_t'(p))
						PLANE_NEAR:   c = UNIT;
						PLANE_FAR:    c = -UNIT;
						PLANE_LEFT:   a = UNIT;
						PLANE_RIGHT:  a = -UNIT;
						PLANE_TOP:    b = -UNIT;
						PLANE_BOTTOM: b = UNIT;
						default: ;
					endcase
				end
				PLANES_TILTED: begin
					a = int'($urandom_range(2 * UNIT)) - UNIT;
					b = int'($urandom_range(2 * UNIT)) - UNIT;
					c = int'($urandom_range(2 * UNIT)) - UNIT;
					d = $urandom_range(20000);
				end
				PLANES_RANDOM: begin
					a = $urandom;
					b = $urandom;
					c = $urandom;
					d = $urandom;
				end
				PLANES_MAX: begin
					a = COEF_MAX;
					b = COEF_MAX;
					c = COEF_MAX;
					d = COEF_MAX;
				end
				default: begin
					a = COEF_MIN;
					b = COEF_MIN;
					c = COEF_MIN;
					d = COEF_MIN;
				end
			endcase
			load_plane(plane_idx_t'(p), pack_plane(a, b, c, d));
		end
	endtask

	// Present one volume word and hold it until taken
	task automatic send_volume(input logic command, input int first_x, input int first_y,
		input int first_z, input int max_x, input int max_y, input int max_z, input int radius);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			volume_ch.valid = 1'b0;
			@(negedge clk);
		end
		volume_ch.command   = command;
		volume_ch.first_x   = first_x[COORD_W-1:0];
		volume_ch.first_y   = first_y[COORD_W-1:0];
		volume_ch.first_z   = first_z[COORD_W-1:0];
		volume_ch.box_max_x = max_x[COORD_W-1:0];
		volume_ch.box_max_y = max_y[COORD_W-1:0];
		volume_ch.box_max_z = max_z[COORD_W-1:0];
		volume_ch.radius    = radius[COORD_W-2:0];
		volume_ch.valid     = 1'b1;
		do
			@(posedge clk);
		while (!volume_ch.ready);
	endtask

	task automatic send_random_volume();
		int   lx, ly, lz, hx, hy, hz, t;
		logic command;
		command = 1'($urandom_range(1));
		lx = random_coord();
		ly = random_coord();
		lz = random_coord();
		hx = random_coord();
		hy = random_coord();
		hz = random_coord();
		// order most boxes min to max, leave some swapped
		if (command == CMD_BOX && $urandom_range(9) < 8) begin
			if (lx > hx) begin t = lx; lx = hx; hx = t; end
			if (ly > hy) begin t = ly; ly = hy; hy = t; end
			if (lz > hz) begin t = lz; lz = hz; hz = t; end
		end
		send_volume(command, lx, ly, lz, hx, hy, hz, random_radius());
	endtask

	// Hold the volume channel until every verdict is back
	task automatic drain();
		@(negedge clk);
		volume_ch.valid = 1'b0;
		wait (outstanding == 0);
	endtask

	initial begin
		int phase, setting, n;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = PLANE_NEAR;
		cfg_data             = '0;
		volume_ch.valid      = 1'b0;
		volume_ch.command    = CMD_SPHERE;
		volume_ch.first_x    = '0;
		volume_ch.first_y    = '0;
		volume_ch.first_z    = '0;
		volume_ch.box_max_x  = '0;
		volume_ch.box_max_y  = '0;
		volume_ch.box_max_z  = '0;
		volume_ch.radius     = '0;
		verdict_ch.ready     = 1'b0;
		send_idle_pct        = 6;
		recv_idle_pct        = 48;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Planes all zero after reset: everything visible
		send_volume(CMD_SPHERE, COEF_MIN, COEF_MIN, COEF_MIN, 0, 0, 0, 0);
		send_volume(CMD_BOX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX,
			RADIUS_MAX);
		send_volume(CMD_BOX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, 0);
		send_volume(CMD_SPHERE, COEF_MAX, COEF_MAX, COEF_MAX, 0, 0, 0, RADIUS_MAX);
		drain();

		// Cube of half size 100 with unit normals; writes past the last plane must not land
		load_plane(PLANE_NEAR,   pack_plane(0, 0, UNIT, 100));
		load_plane(PLANE_FAR,    pack_plane(0, 0, -UNIT, 100));
		load_plane(PLANE_LEFT,   pack_plane(UNIT, 0, 0, 100));
		load_plane(PLANE_RIGHT,  pack_plane(-UNIT, 0, 0, 100));
		load_plane(PLANE_TOP,    pack_plane(0, -UNIT, 0, 100));
		load_plane(PLANE_BOTTOM, pack_plane(0, UNIT, 0, 100));
		load_plane(CFG_IDX_W'(NUM_PLANES),
			pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
		load_plane(CFG_IDX_W'(NUM_PLANES + 1),
			pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
		send_volume(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_SPHERE, 200, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_SPHERE, 200, 0, 0, 0, 0, 0, 100);
		send_volume(CMD_SPHERE, 200, 0, 0, 0, 0, 0, 99);
		send_volume(CMD_SPHERE, 100, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_SPHERE, 101, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_SPHERE, COEF_MAX, COEF_MAX, COEF_MAX, 0, 0, 0, RADIUS_MAX);
		send_volume(CMD_SPHERE, COEF_MIN, COEF_MIN, COEF_MIN, 0, 0, 0, 0);
		send_volume(CMD_BOX, 150, 0, 0, 300, 0, 0, 0);
		send_volume(CMD_BOX, -300, -300, -300, 300, 300, 300, 0);
		send_volume(CMD_BOX, 300, 300, 300, -300, -300, -300, 0);
		send_volume(CMD_BOX, 300, 0, 0, 150, 0, 0, 0);
		send_volume(CMD_BOX, 100, 0, 0, 200, 0, 0, 0);
		send_volume(CMD_BOX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX, 0);

		// Random volumes over several plane sets in each idling pattern
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 6;  recv_idle_pct = 48; end
				1: begin send_idle_pct = 48; recv_idle_pct = 6;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (setting = PLANES_AXIS; setting <= PLANES_MIN; setting++) begin
				drain();
				load_plane_set(plane_set_t'(setting));
				for (n = 0; n < ITEMS_PER_SETTING; n++)
					send_random_volume();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
